>>> sv/btftm_pkg.sv
// ---------------------------------------------------------------------------
// btftm_pkg
// Shared types and constants for the byte to 8-FSK tone mapper.
// ---------------------------------------------------------------------------
package btftm_pkg;

  localparam int unsigned NUM_TONES = 8;
  localparam int unsigned SYM_W     = 3;
  localparam int unsigned TONE_W    = 6;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned MAX_SYMS  = 4;
  localparam int unsigned SYMS_W    = MAX_SYMS * SYM_W;
  localparam int unsigned SCNT_W    = 2;
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = 1;
  localparam int unsigned QCNT_W    = 2;

  typedef logic [TONE_W-1:0] tone_t;
  typedef logic [SYM_W-1:0]  sym_t;

  // tone table after reset
  localparam tone_t TONE_RESET [NUM_TONES] = '{
    6'd32, 6'd31, 6'd30, 6'd29, 6'd28, 6'd27, 6'd26, 6'd25
  };

  // one queued byte: its symbols top-aligned, index of the last one, end flag
  typedef struct packed {
    logic [SYMS_W-1:0] syms;
    logic [SCNT_W-1:0] last_idx;
    logic              msg_end;
  } grp_t;

endpackage

>>> sv/byte_to_fsk_tone_mapper_top.sv
// ---------------------------------------------------------------------------
// byte_to_fsk_tone_mapper_top
// 8-FSK mapper: bytes in, MSB first, 3-bit symbols and tone numbers out.
// ---------------------------------------------------------------------------
// Each accepted byte yields two or three symbols (up to four on the final
// byte, which pads leftover bits with zeros and marks the last symbol with
// message_end). One symbol leaves per cycle while out_stall is low, and that
// output port sets the byte rate. A two-entry queue between the byte front
// end and the symbol back end lets bytes be taken while earlier symbols are
// still going out. With the back end idle, an accepted byte is written into
// the queue and its first symbol then goes out from the back end's output
// register.
// The tone table is written through the cfg port, index 0 to 7.
// ---------------------------------------------------------------------------
module byte_to_fsk_tone_mapper_top import btftm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [TONE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_final_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TONE_W-1:0] out_tone_number,
  output logic [SYM_W-1:0]  out_symbol_value,
  output logic              out_message_end
);

  grp_t push_data;
  grp_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;

  // byte front end
  btftm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_push        (push),
    .q_data        (push_data)
  );

  // group queue
  btftm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // symbol back end
  btftm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .head             (head),
    .q_empty          (q_empty),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_number  (out_tone_number),
    .out_symbol_value (out_symbol_value),
    .out_message_end  (out_message_end)
  );

endmodule

>>> sv/btftm_front.sv
// ---------------------------------------------------------------------------
// btftm_front
// Accepts bytes, merges them with leftover bits and cuts 3-bit symbols.
// ---------------------------------------------------------------------------
module btftm_front import btftm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_final_byte,
  input  logic              q_full,
  output logic              q_push,
  output grp_t              q_data
);

  logic [1:0]  res_bits_r, res_bits_nxt;
  logic [1:0]  res_cnt_r, res_cnt_nxt;
  logic [11:0] word_raw;
  logic [11:0] word_al;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  // leftover bits then byte, top-aligned in 12 bits with zero padding below
  assign word_raw = {res_bits_r, in_data_byte, 2'b00};
  assign word_al  = word_raw << (2'd2 - res_cnt_r);

  // symbol count depends on total bits (8, 9 or 10) and the final flag
  always_comb begin
    q_data.syms    = word_al;
    q_data.msg_end = in_final_byte;
    case (res_cnt_r)
      2'd0:    q_data.last_idx = in_final_byte ? 2'd2 : 2'd1;
      2'd1:    q_data.last_idx = 2'd2;
      default: q_data.last_idx = in_final_byte ? 2'd3 : 2'd2;
    endcase
  end

  // next leftover bits
  always_comb begin
    res_bits_nxt = res_bits_r;
    res_cnt_nxt  = res_cnt_r;
    if (accept) begin
      if (in_final_byte) begin
        res_bits_nxt = 2'd0;
        res_cnt_nxt  = 2'd0;
      end else begin
        case (res_cnt_r)
          2'd0: begin
            res_bits_nxt = in_data_byte[1:0];
            res_cnt_nxt  = 2'd2;
          end
          2'd1: begin
            res_bits_nxt = 2'd0;
            res_cnt_nxt  = 2'd0;
          end
          default: begin
            res_bits_nxt = {1'b0, in_data_byte[0]};
            res_cnt_nxt  = 2'd1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_bits_r <= 2'd0;
      res_cnt_r  <= 2'd0;
    end else begin
      res_bits_r <= res_bits_nxt;
      res_cnt_r  <= res_cnt_nxt;
    end
  end

endmodule

>>> sv/btftm_queue.sv
// ---------------------------------------------------------------------------
// btftm_queue
// Two-entry queue of symbol groups between front and back.
// ---------------------------------------------------------------------------
module btftm_queue import btftm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t push_data,
  input  logic pop,
  output grp_t head,
  output logic empty,
  output logic full
);

  grp_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> sv/btftm_back.sv
// ---------------------------------------------------------------------------
// btftm_back
// Sends one symbol per cycle from the queue head through the tone table unless stalled.
// ---------------------------------------------------------------------------
module btftm_back import btftm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [IDX_W-1:0] cfg_index,
  input  tone_t            cfg_data,
  input  grp_t             head,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output tone_t            out_tone_number,
  output sym_t             out_symbol_value,
  output logic             out_message_end
);

  tone_t             tone_r [NUM_TONES];
  logic [SCNT_W-1:0] sel_r, sel_nxt;
  logic              valid_r, valid_nxt;
  tone_t             tone_out_r;
  sym_t              sym_out_r;
  logic              end_out_r;
  logic              load;
  logic              at_last;
  sym_t              cur_sym;

  // pick the current symbol from the top-aligned group
  assign cur_sym = head.syms[SYMS_W-1 - SYM_W*sel_r -: SYM_W];
  assign at_last = (sel_r == head.last_idx);
  assign load    = !q_empty && (!valid_r || !out_stall);
  assign q_pop   = load && at_last;

  // symbol index and output valid
  always_comb begin
    sel_nxt   = sel_r;
    valid_nxt = valid_r;
    if (load) begin
      sel_nxt   = at_last ? '0 : sel_r + 1'b1;
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      tone_out_r <= tone_r[cur_sym];
      sym_out_r  <= cur_sym;
      end_out_r  <= head.msg_end && at_last;
    end
  end

  // tone table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r <= TONE_RESET;
    end else if (cfg_wr_en) begin
      tone_r[cfg_index] <= cfg_data;
    end
  end

  assign out_valid        = valid_r;
  assign out_tone_number  = tone_out_r;
  assign out_symbol_value = sym_out_r;
  assign out_message_end  = end_out_r;

endmodule

>>> sim/btftm_tone_checker.sv
// ---------------------------------------------------------------------------
// btftm_tone_checker
// Scoreboard for the byte to 8-FSK tone mapper: it tracks the tone table and
// the leftover bits, turns each accepted byte into the tones it should make,
// and compares them in order with the tones the block sends out.
// ---------------------------------------------------------------------------
module btftm_tone_checker import btftm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [TONE_W-1:0] cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_final_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [TONE_W-1:0] out_tone_number,
  input  logic [SYM_W-1:0]  out_symbol_value,
  input  logic              out_message_end,
  output int unsigned       tones_pending,
  output int unsigned       tones_checked,
  output int unsigned       error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_CAP = 100;

  typedef struct packed {
    tone_t tone;
    sym_t  sym;
    logic  msg_end;
  } tone_exp_t;

  tone_t       tone_tbl [NUM_TONES];
  logic [1:0]  carry_bits;
  int unsigned carry_cnt;
  tone_exp_t   expected_tones [$];

  function automatic void queue_tone(input sym_t s, input logic last);
    tone_exp_t e;
    e.tone    = tone_tbl[s];
    e.sym     = s;
    e.msg_end = last;
    expected_tones.push_back(e);
  endfunction

  // cut the carried bits plus the new byte into 3-bit symbols, msb first
  task automatic map_byte_to_tones(input logic [BYTE_W-1:0] data, input logic fin);
    logic [9:0]  stream;
    int unsigned width;
    int unsigned n_sym;
    int unsigned spare;
    int unsigned rem;
    stream = {carry_bits, data};
    width  = carry_cnt + BYTE_W;
    n_sym  = width / SYM_W;
    spare  = width % SYM_W;
    for (int unsigned k = 0; k < n_sym; k++) begin
      queue_tone(sym_t'(stream >> (width - SYM_W * (k + 1))),
                 fin && spare == 0 && k + 1 == n_sym);
    end
    rem = stream & ((1 << spare) - 1);
    if (fin) begin
      // leftover bits go out left-aligned with zero padding
      if (spare > 0) begin
        queue_tone(sym_t'(rem << (SYM_W - spare)), 1'b1);
      end
      carry_bits = '0;
      carry_cnt  = 0;
    end else begin
      carry_bits = rem[1:0];
      carry_cnt  = spare;
    end
  endtask

  // compare first, then predict: a byte never shows up as a tone at its own edge
  always @(posedge clk) begin
    tone_exp_t want;
    logic      bad;
    if (!rst_n) begin
      for (int i = 0; i < NUM_TONES; i++) begin
        tone_tbl[i] = TONE_RESET[i];
      end
      carry_bits = '0;
      carry_cnt  = 0;
      expected_tones.delete();
      tones_checked = 0;
      error_count   = 0;
    end else begin
      if (cfg_wr_en && cfg_index < NUM_TONES) begin
        tone_tbl[cfg_index] = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_tones.size() == 0) begin
          if (error_count < REPORT_CAP) begin
            $display("%0t: unexpected tone, expected none, actual tone %0d symbol %0d end %0b",
                     $time, out_tone_number, out_symbol_value, out_message_end);
          end
          error_count++;
        end else begin
          want = expected_tones.pop_front();
          bad  = 1'b0;
          if (out_tone_number !== want.tone) begin
            if (error_count < REPORT_CAP) begin
              $display("%0t: tone_number expected %0d actual %0d",
                       $time, want.tone, out_tone_number);
            end
            bad = 1'b1;
          end
          if (out_symbol_value !== want.sym) begin
            if (error_count < REPORT_CAP) begin
              $display("%0t: symbol_value expected %0d actual %0d",
                       $time, want.sym, out_symbol_value);
            end
            bad = 1'b1;
          end
          if (out_message_end !== want.msg_end) begin
            if (error_count < REPORT_CAP) begin
              $display("%0t: message_end expected %0b actual %0b",
                       $time, want.msg_end, out_message_end);
            end
            bad = 1'b1;
          end
          if (bad) begin
            error_count++;
          end
          tones_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        map_byte_to_tones(in_data_byte, in_final_byte);
      end
    end
    tones_pending = expected_tones.size();
  end

endmodule

>>> sim/tb_byte_to_fsk_tone_mapper_top.sv
// ---------------------------------------------------------------------------
// tb_byte_to_fsk_tone_mapper_top
// Stimulus and verdict for the byte to 8-FSK tone mapper.
// ---------------------------------------------------------------------------
// A directed burst of short messages hits padding, no padding and back to
// back final bytes, then random messages run under several tone tables
// (reset values, all zero, all ones, a bit stripe, random). Both sides idle
// in short random bursts, except in the no-idle phases and the closing one.
// The checker beside the block predicts every tone and counts errors.
// ---------------------------------------------------------------------------
module tb_byte_to_fsk_tone_mapper_top import btftm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS = 70;
  localparam int unsigned NUM_PHASES  = 6;

  // tone table styles
  localparam int TBL_DEFAULT = 0;
  localparam int TBL_ZERO    = 1;
  localparam int TBL_FULL    = 2;
  localparam int TBL_STRIPE  = 3;
  localparam int TBL_RANDOM  = 4;

  localparam int          PHASE_TABLE [NUM_PHASES] = '{
    TBL_DEFAULT, TBL_ZERO, TBL_FULL, TBL_STRIPE, TBL_RANDOM, TBL_RANDOM
  };
  localparam int unsigned PHASE_IDLE  [NUM_PHASES] = '{25, 35, 0, 15, 40, 0};

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_wr_en     = 1'b0;
  logic [IDX_W-1:0]  cfg_index     = '0;
  logic [TONE_W-1:0] cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_data_byte  = '0;
  logic              in_final_byte = 1'b0;
  logic              out_valid;
  logic              out_stall     = 1'b0;
  logic [TONE_W-1:0] out_tone_number;
  logic [SYM_W-1:0]  out_symbol_value;
  logic              out_message_end;

  int unsigned tones_pending;
  int unsigned tones_checked;
  int unsigned error_count;
  int unsigned idle_pct    = 0;
  bit          quiet_tail  = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent  = 0;
  int unsigned msgs_sent   = 0;

  byte_to_fsk_tone_mapper_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_number  (out_tone_number),
    .out_symbol_value (out_symbol_value),
    .out_message_end  (out_message_end)
  );

  btftm_tone_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tone_number  (out_tone_number),
    .out_symbol_value (out_symbol_value),
    .out_message_end  (out_message_end),
    .tones_pending    (tones_pending),
    .tones_checked    (tones_checked),
    .error_count      (error_count)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("byte_to_fsk_tone_mapper_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item and hold it until taken, then maybe go idle
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    bytes_sent++;
    if (fin) begin
      msgs_sent++;
    end
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every predicted tone to come out
  task automatic drain_tones();
    in_valid <= 1'b0;
    do @(negedge clk); while (tones_pending != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_tone_table(input int style);
    tone_t v;
    for (int i = 0; i < NUM_TONES; i++) begin
      case (style)
        TBL_DEFAULT: v = TONE_RESET[i];
        TBL_ZERO:    v = '0;
        TBL_FULL:    v = '1;
        TBL_STRIPE:  v = i[0] ? 6'h2A : 6'h15;
        default:     v = tone_t'($urandom);
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int unsigned phase_count;
    int unsigned len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-byte messages, two leftover bits padded
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // one leftover bit padded
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // message ends on a symbol boundary, no padding symbol
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b1);
    idle_pct = 30;
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // longer message walking all symbol values
    send_byte(8'h05, 1'b0);
    send_byte(8'h39, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    // back to back final bytes: residue must be cleared
    send_byte(8'h7F, 1'b1);
    send_byte(8'h01, 1'b1);

    // hold off until the block has emptied
    drain_tones();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_tones();
      load_tone_table(PHASE_TABLE[ph]);
      idle_pct   = PHASE_IDLE[ph];
      quiet_tail = (ph == NUM_PHASES - 1);
      phase_count = 0;
      while (phase_count < PHASE_ITEMS) begin
        // mostly short messages, some long ones to cycle the residue
        len = ($urandom_range(0, 9) < 3) ? 1 : $urandom_range(2, 14);
        for (int unsigned i = 0; i < len; i++) begin
          send_byte(BYTE_W'($urandom), i + 1 == len);
          phase_count++;
        end
      end
    end

    drain_tones();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes in %0d messages, %0d tones checked",
             bytes_sent, msgs_sent, tones_checked);
    $display("tables used: reset values, all zero, all ones, bit stripe, random");
    if (error_count == 0 && tones_pending == 0) begin
      $display("byte_to_fsk_tone_mapper_top: match");
    end else begin
      $display("byte_to_fsk_tone_mapper_top: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/btftm_pkg.sv
sv/btftm_front.sv
sv/btftm_queue.sv
sv/btftm_back.sv
sv/byte_to_fsk_tone_mapper_top.sv
sim/btftm_tone_checker.sv
sim/tb_byte_to_fsk_tone_mapper_top.sv
